>>> rtl/tcnw_pkg.sv
`default_nettype none
package tcnw_pkg;

	localparam logic [1:0] MODE_CHAR = 2'd0;
	localparam logic [1:0] MODE_DEC  = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [7:0] CHR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHR_ZERO    = 8'h30;
	localparam logic [7:0] CHR_MINUS   = 8'h2D;
	localparam logic [7:0] CHR_X       = 8'h78;

	localparam logic [7:0]  COLOR_RESET = 8'h07;
	localparam logic [3:0]  HEX_DIGITS  = 4'd8;
	localparam int          DEC_DIGITS  = 10;
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam logic [2:0] CH_VALUE = 3'd0;
	localparam logic [2:0] CH_ZERO  = 3'd1;
	localparam logic [2:0] CH_MINUS = 3'd2;
	localparam logic [2:0] CH_X     = 3'd3;
	localparam logic [2:0] CH_HEX   = 3'd4;
	localparam logic [2:0] CH_DIGIT = 3'd5;

	localparam logic [1:0] LAST_NO   = 2'd0;
	localparam logic [1:0] LAST_YES  = 2'd1;
	localparam logic [1:0] LAST_CNT1 = 2'd2;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_NEG   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_PUSH  = 3'd3;
	localparam logic [2:0] OP_POP   = 3'd4;
	localparam logic [2:0] OP_HEX   = 3'd5;
	localparam logic [2:0] OP_LOAD8 = 3'd6;

	localparam logic [2:0] J_NONE     = 3'd0;
	localparam logic [2:0] J_MAG_ZERO = 3'd1;
	localparam logic [2:0] J_MAG_POS  = 3'd2;
	localparam logic [2:0] J_Q_NZ     = 3'd3;
	localparam logic [2:0] J_NOT_LAST = 3'd4;

	localparam logic [3:0] UA_CHR  = 4'd0;
	localparam logic [3:0] UA_DEC  = 4'd1;
	localparam logic [3:0] UA_SIGN = 4'd2;
	localparam logic [3:0] UA_NEG  = 4'd3;
	localparam logic [3:0] UA_DIV  = 4'd4;
	localparam logic [3:0] UA_PUSH = 4'd5;
	localparam logic [3:0] UA_POP  = 4'd6;
	localparam logic [3:0] UA_DZ   = 4'd7;
	localparam logic [3:0] UA_HEX  = 4'd8;
	localparam logic [3:0] UA_HEXX = 4'd9;
	localparam logic [3:0] UA_HEXL = 4'd10;

	typedef struct packed {
		logic       emit;
		logic [2:0] chsel;
		logic [1:0] lastsel;
		logic [2:0] op;
		logic [2:0] jcond;
		logic [3:0] target;
		logic       fin;
	} uword_t;

	typedef struct packed {
		logic       run;
		logic       emit;
		logic [2:0] chsel;
		logic [1:0] lastsel;
		logic [2:0] op;
	} ctl_t;

	typedef struct packed {
		logic mag_zero;
		logic mag_neg;
		logic q_nz;
		logic cnt_one;
		logic cnt_zero;
		logic out_free;
	} sts_t;

	function automatic uword_t mk(input logic emit, input logic [2:0] chsel,
			input logic [1:0] lastsel, input logic [2:0] op, input logic [2:0] jcond,
			input logic [3:0] target, input logic fin);
		uword_t w;
		w.emit    = emit;
		w.chsel   = chsel;
		w.lastsel = lastsel;
		w.op      = op;
		w.jcond   = jcond;
		w.target  = target;
		w.fin     = fin;
		return w;
	endfunction

	function automatic uword_t ucode(input logic [3:0] addr);
		uword_t w;
		w = mk(1'b0, CH_VALUE, LAST_NO, OP_NONE, J_NONE, UA_CHR, 1'b1);
		unique case (addr)
			UA_CHR:  w = mk(1'b1, CH_VALUE, LAST_YES, OP_NONE, J_NONE, UA_CHR, 1'b1);
			UA_DEC:  w = mk(1'b0, CH_VALUE, LAST_NO, OP_NONE, J_MAG_ZERO, UA_DZ, 1'b0);
			UA_SIGN: w = mk(1'b0, CH_VALUE, LAST_NO, OP_NONE, J_MAG_POS, UA_DIV, 1'b0);
			UA_NEG:  w = mk(1'b1, CH_MINUS, LAST_NO, OP_NEG, J_NONE, UA_CHR, 1'b0);
			UA_DIV:  w = mk(1'b0, CH_VALUE, LAST_NO, OP_MUL, J_NONE, UA_CHR, 1'b0);
			UA_PUSH: w = mk(1'b0, CH_VALUE, LAST_NO, OP_PUSH, J_Q_NZ, UA_DIV, 1'b0);
			UA_POP:  w = mk(1'b1, CH_DIGIT, LAST_CNT1, OP_POP, J_NOT_LAST, UA_POP, 1'b1);
			UA_DZ:   w = mk(1'b1, CH_ZERO, LAST_YES, OP_NONE, J_NONE, UA_CHR, 1'b1);
			UA_HEX:  w = mk(1'b1, CH_ZERO, LAST_NO, OP_NONE, J_NONE, UA_CHR, 1'b0);
			UA_HEXX: w = mk(1'b1, CH_X, LAST_NO, OP_LOAD8, J_NONE, UA_CHR, 1'b0);
			UA_HEXL: w = mk(1'b1, CH_HEX, LAST_CNT1, OP_HEX, J_NOT_LAST, UA_HEXL, 1'b1);
			default: w = mk(1'b0, CH_VALUE, LAST_NO, OP_NONE, J_NONE, UA_CHR, 1'b1);
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'd0, n};
		end else begin
			c = 8'h37 + {4'd0, n};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/text_console_number_writer.sv
`default_nettype none
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tuser = mode, s_tdata = value
// m_*       out  m_tvalid / m_tready    m_tdata = cell_index, cell_word; m_tlast = last
// cfg_*     in   cfg_valid / cfg_ready  cfg_data = text_color
//
// A request is taken only while the sequencer is idle; the microprogram starts in the
// cycle after acceptance. Character: 1 step. Hex: 10 steps. Decimal: 2 to 3 steps,
// then 2 steps per digit (multiply by reciprocal, then push) and 1 step per cell.
// Each cell step waits while the output register is full and m_tready is low.
// Reset clears the cursor, the sequencer and the output valid; text_color returns to 7.
module text_console_number_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [10:0] cell_index, [26:11] cell_word, rest zero
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	tcnw_pkg::ctl_t ctl;
	tcnw_pkg::sts_t sts;
	logic           busy;
	logic           start;
	logic [10:0]    out_index;
	logic [15:0]    out_word;

	assign s_tready  = !busy;
	assign start     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	tcnw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (s_tuser),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	tcnw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_color (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_index (out_index),
		.out_word  (out_word),
		.out_last  (m_tlast),
		.out_ready (m_tready)
	);

	assign m_tdata = {5'd0, out_word, out_index};

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.run && ctl.emit && ctl.chsel == tcnw_pkg::CH_DIGIT) |-> !sts.cnt_zero)
		else $error("digit pop from empty stack");

	a_hex_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.run && ctl.chsel == tcnw_pkg::CH_HEX) |-> !sts.cnt_zero)
		else $error("hex digit count underflow");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && s_tuser != tcnw_pkg::MODE_NONE) |=> !s_tready)
		else $error("request accepted without starting the sequencer");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.run && ctl.emit) |-> sts.out_free)
		else $error("cell step advanced with output register full");

endmodule
`default_nettype wire

>>> rtl/tcnw_seq.sv
`default_nettype none
module tcnw_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     mode,
	input  wire tcnw_pkg::sts_t sts,
	output tcnw_pkg::ctl_t      ctl,
	output logic                busy
);

	logic [3:0]       pc_q;
	logic             busy_q;
	tcnw_pkg::uword_t word;
	logic             advance;
	logic             taken;

	assign word    = tcnw_pkg::ucode(pc_q);
	assign advance = busy_q && (!word.emit || sts.out_free);
	assign busy    = busy_q;

	always_comb begin
		unique case (word.jcond)
			tcnw_pkg::J_MAG_ZERO: taken = sts.mag_zero;
			tcnw_pkg::J_MAG_POS:  taken = !sts.mag_neg;
			tcnw_pkg::J_Q_NZ:     taken = sts.q_nz;
			tcnw_pkg::J_NOT_LAST: taken = !sts.cnt_one;
			default:              taken = 1'b0;
		endcase
	end

	assign ctl.run     = advance;
	assign ctl.emit    = word.emit;
	assign ctl.chsel   = word.chsel;
	assign ctl.lastsel = word.lastsel;
	assign ctl.op      = word.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= tcnw_pkg::UA_CHR;
		end else if (start) begin
			unique case (mode)
				tcnw_pkg::MODE_CHAR: begin
					busy_q <= 1'b1;
					pc_q   <= tcnw_pkg::UA_CHR;
				end
				tcnw_pkg::MODE_DEC: begin
					busy_q <= 1'b1;
					pc_q   <= tcnw_pkg::UA_DEC;
				end
				tcnw_pkg::MODE_HEX: begin
					busy_q <= 1'b1;
					pc_q   <= tcnw_pkg::UA_HEX;
				end
				default: busy_q <= 1'b0;
			endcase
		end else if (advance) begin
			if (taken) begin
				pc_q <= word.target;
			end else if (word.fin) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/tcnw_datapath.sv
`default_nettype none
module tcnw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [31:0]    value,
	input  wire logic           cfg_we,
	input  wire logic [7:0]     cfg_color,
	input  wire tcnw_pkg::ctl_t ctl,
	output tcnw_pkg::sts_t      sts,
	output logic                out_valid,
	output logic [10:0]         out_index,
	output logic [15:0]         out_word,
	output logic                out_last,
	input  wire logic           out_ready
);

	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int LN_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [31:0]      mag_q;
	logic [63:0]      prod_q;
	logic [3:0]       cnt_q;
	logic [3:0]       stk_q [tcnw_pkg::DEC_DIGITS];
	logic [COL_W-1:0] col_q;
	logic [LN_W-1:0]  line_q;
	logic [7:0]       color_q;
	logic             out_valid_q;
	logic [10:0]      out_index_q;
	logic [15:0]      out_word_q;
	logic             out_last_q;

	logic [31:0] quo;
	logic [31:0] rem;
	logic [3:0]  top_idx;
	logic [7:0]  ch;
	logic        is_last;
	logic        write_cell;
	logic        newline;
	logic [11:0] index_full;

	assign quo     = {3'd0, prod_q[63:tcnw_pkg::RECIP_SHIFT]};
	assign rem     = mag_q - ((quo << 3) + (quo << 1));
	assign top_idx = cnt_q - 4'd1;

	always_comb begin
		unique case (ctl.chsel)
			tcnw_pkg::CH_ZERO:  ch = tcnw_pkg::CHR_ZERO;
			tcnw_pkg::CH_MINUS: ch = tcnw_pkg::CHR_MINUS;
			tcnw_pkg::CH_X:     ch = tcnw_pkg::CHR_X;
			tcnw_pkg::CH_HEX:   ch = tcnw_pkg::hex_char(mag_q[31:28]);
			tcnw_pkg::CH_DIGIT: ch = tcnw_pkg::CHR_ZERO + {4'd0, stk_q[top_idx]};
			default:            ch = mag_q[7:0];
		endcase
	end

	always_comb begin
		unique case (ctl.lastsel)
			tcnw_pkg::LAST_YES:  is_last = 1'b1;
			tcnw_pkg::LAST_CNT1: is_last = (cnt_q == 4'd1);
			default:             is_last = 1'b0;
		endcase
	end

	assign newline    = ctl.run && ctl.emit && (ch == tcnw_pkg::CHR_NEWLINE);
	assign write_cell = ctl.run && ctl.emit && (ch != tcnw_pkg::CHR_NEWLINE);
	assign index_full = 12'({{(12-LN_W){1'b0}}, line_q} * 12'(COLUMNS))
		+ {{(12-COL_W){1'b0}}, col_q};

	assign sts.mag_zero = (mag_q == 32'd0);
	assign sts.mag_neg  = mag_q[31];
	assign sts.q_nz     = (quo != 32'd0);
	assign sts.cnt_one  = (cnt_q == 4'd1);
	assign sts.cnt_zero = (cnt_q == 4'd0);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= value;
			cnt_q <= 4'd0;
		end else if (ctl.run) begin
			unique case (ctl.op)
				tcnw_pkg::OP_NEG: mag_q <= ~mag_q + 32'd1;
				tcnw_pkg::OP_MUL: prod_q <= 64'(mag_q) * 64'(tcnw_pkg::RECIP_TEN);
				tcnw_pkg::OP_PUSH: begin
					stk_q[cnt_q] <= rem[3:0];
					cnt_q        <= cnt_q + 4'd1;
					mag_q        <= quo;
				end
				tcnw_pkg::OP_POP: cnt_q <= cnt_q - 4'd1;
				tcnw_pkg::OP_HEX: begin
					mag_q <= mag_q << 4;
					cnt_q <= cnt_q - 4'd1;
				end
				tcnw_pkg::OP_LOAD8: cnt_q <= tcnw_pkg::HEX_DIGITS;
				default: ;
			endcase
		end
		if (write_cell) begin
			out_index_q <= index_full[10:0];
			out_word_q  <= {color_q, ch};
			out_last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			line_q      <= '0;
			color_q     <= tcnw_pkg::COLOR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_color;
			end
			if (newline || (write_cell && col_q == COL_W'(COLUMNS - 1))) begin
				col_q <= '0;
				if (line_q == LN_W'(ROWS - 1)) begin
					line_q <= '0;
				end else begin
					line_q <= line_q + LN_W'(1);
				end
			end else if (write_cell) begin
				col_q <= col_q + COL_W'(1);
			end
			if (write_cell) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

>>> test/tb_text_console_number_writer.sv
module tb_text_console_number_writer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam logic [7:0] CHR_A = 8'h41;
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [10:0] cell_idx;
		logic [15:0] word;
		logic        last;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	request_t print_requests[$];
	cell_t cell_writes_due[$];

	logic [7:0] text_color = tcnw_pkg::COLOR_RESET;
	logic [4:0] pen_row = '0;
	logic [6:0] pen_col = '0;

	logic s_fire = 1'b0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int errors = 0;
	int stall_cycles = 0;

	text_console_number_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic next_row();
		pen_col = '0;
		if (pen_row == ROWS - 1) begin
			pen_row = '0;
		end else begin
			pen_row = pen_row + 5'd1;
		end
	endtask

	task automatic put_char(input logic [7:0] ch);
		cell_t c;
		if (ch == tcnw_pkg::CHR_NEWLINE) begin
			next_row();
		end else begin
			c.cell_idx = 11'(pen_row * COLUMNS + pen_col);
			c.word = {text_color, ch};
			c.last = 1'b0;
			cell_writes_due.push_back(c);
			if (pen_col == COLUMNS - 1) begin
				next_row();
			end else begin
				pen_col = pen_col + 7'd1;
			end
		end
	endtask

	task automatic print_request_cells(input logic [1:0] mode, input logic [31:0] v);
		int due_before;
		int nd;
		int sh;
		logic [31:0] mag;
		logic [3:0] nib;
		logic [7:0] digs[10];
		cell_t c;
		due_before = cell_writes_due.size();
		case (mode)
			tcnw_pkg::MODE_CHAR: begin
				put_char(v[7:0]);
			end
			tcnw_pkg::MODE_DEC: begin
				if (v == 32'd0) begin
					put_char(tcnw_pkg::CHR_ZERO);
				end else begin
					mag = v;
					if (v[31]) begin
						put_char(tcnw_pkg::CHR_MINUS);
						mag = ~v + 32'd1;
					end
					nd = 0;
					while (mag != 32'd0) begin
						digs[nd] = tcnw_pkg::CHR_ZERO + 8'(mag % 32'd10);
						nd++;
						mag = mag / 32'd10;
					end
					while (nd > 0) begin
						nd--;
						put_char(digs[nd]);
					end
				end
			end
			tcnw_pkg::MODE_HEX: begin
				put_char(tcnw_pkg::CHR_ZERO);
				put_char(tcnw_pkg::CHR_X);
				for (sh = 28; sh >= 0; sh -= 4) begin
					nib = 4'((v >> sh) & 32'hF);
					if (nib < 4'd10) begin
						put_char(tcnw_pkg::CHR_ZERO + {4'd0, nib});
					end else begin
						put_char(CHR_A + {4'd0, nib} - 8'd10);
					end
				end
			end
			default: begin
			end
		endcase
		if (cell_writes_due.size() > due_before) begin
			c = cell_writes_due.pop_back();
			c.last = 1'b1;
			cell_writes_due.push_back(c);
		end
	endtask

	always @(posedge clk) begin : monitor
		cell_t due;
		s_fire <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (cell_writes_due.size() == 0) begin
				$display("%0t unexpected cell write: expected none actual index %0d word %h last %b",
					$time, m_tdata[10:0], m_tdata[26:11], m_tlast);
				errors++;
			end else begin
				due = cell_writes_due.pop_front();
				if (m_tdata[10:0] !== due.cell_idx) begin
					$display("%0t cell_index: expected %0d actual %0d",
						$time, due.cell_idx, m_tdata[10:0]);
					errors++;
				end
				if (m_tdata[26:11] !== due.word) begin
					$display("%0t cell_word: expected %h actual %h", $time, due.word, m_tdata[26:11]);
					errors++;
				end
				if (m_tlast !== due.last) begin
					$display("%0t last: expected %b actual %b", $time, due.last, m_tlast);
					errors++;
				end
				if (m_tdata[31:27] !== 5'd0) begin
					$display("%0t tdata padding: expected 0 actual %h", $time, m_tdata[31:27]);
					errors++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			print_request_cells(s_tuser, s_tdata);
		end
	end

	always @(negedge clk) begin : driver
		request_t r;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (print_requests.size() == 0 || $urandom_range(99) < tx_idle_pct) begin
				s_tvalid <= 1'b0;
			end else begin
				r = print_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= r.mode;
				s_tdata <= r.value;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("text_console_number_writer: mismatch");
				$finish;
			end
		end
	end

	task automatic add_request(input logic [1:0] mode, input logic [31:0] value);
		request_t r;
		r.mode = mode;
		r.value = value;
		print_requests.push_back(r);
	endtask

	task automatic add_random_requests(input int count);
		int added;
		int pick;
		logic [31:0] v;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(99);
			v = $urandom;
			if (pick < 35) begin
				if ($urandom_range(9) == 0) begin
					v[7:0] = tcnw_pkg::CHR_NEWLINE;
				end
				add_request(tcnw_pkg::MODE_CHAR, v);
				added++;
			end else if (pick < 65) begin
				v = v >> $urandom_range(31, 0);
				if ($urandom_range(1) == 1) begin
					v = ~v + 32'd1;
				end
				if ($urandom_range(19) == 0) begin
					v = 32'd0;
				end
				add_request(tcnw_pkg::MODE_DEC, v);
				added++;
			end else if (pick < 95) begin
				add_request(tcnw_pkg::MODE_HEX, v);
				added++;
			end else begin
				add_request(tcnw_pkg::MODE_NONE, v);
			end
		end
	endtask

	// hold until every request is taken and every cell write has arrived
	task automatic drain();
		while (print_requests.size() != 0 || s_tvalid || cell_writes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] color);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= color;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		text_color = color;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 16;
		rx_idle_pct = 47;
		add_request(tcnw_pkg::MODE_CHAR, 32'h0000_0041);
		add_request(tcnw_pkg::MODE_CHAR, 32'h0000_0000);
		add_request(tcnw_pkg::MODE_CHAR, 32'h0000_00FF);
		add_request(tcnw_pkg::MODE_CHAR, 32'hFFFF_FF5A);
		add_request(tcnw_pkg::MODE_CHAR, 32'h0000_000A);
		add_request(tcnw_pkg::MODE_CHAR, 32'hABCD_EF0A);
		add_request(tcnw_pkg::MODE_DEC, 32'd0);
		add_request(tcnw_pkg::MODE_DEC, 32'd1);
		add_request(tcnw_pkg::MODE_DEC, 32'd9);
		add_request(tcnw_pkg::MODE_DEC, 32'd10);
		add_request(tcnw_pkg::MODE_DEC, 32'hFFFF_FFFF);
		add_request(tcnw_pkg::MODE_DEC, 32'h7FFF_FFFF);
		add_request(tcnw_pkg::MODE_DEC, 32'h8000_0000);
		add_request(tcnw_pkg::MODE_DEC, 32'd1000000000);
		add_request(tcnw_pkg::MODE_DEC, 32'hFFFF_FFF6);
		add_request(tcnw_pkg::MODE_HEX, 32'h0000_0000);
		add_request(tcnw_pkg::MODE_HEX, 32'hFFFF_FFFF);
		add_request(tcnw_pkg::MODE_HEX, 32'h0123_ABCD);
		add_request(tcnw_pkg::MODE_HEX, 32'h89AB_CDEF);
		add_request(tcnw_pkg::MODE_NONE, 32'hFFFF_FFFF);
		add_request(tcnw_pkg::MODE_NONE, 32'h0000_0000);
		add_request(tcnw_pkg::MODE_CHAR, 32'h0000_0021);
		drain();

		write_color(8'hFF);
		add_random_requests(135);
		drain();

		tx_idle_pct = 47;
		rx_idle_pct = 16;
		write_color(8'h00);
		add_random_requests(135);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_color(8'($urandom_range(255)));
		add_random_requests(145);
		drain();

		if (errors == 0) begin
			$display("text_console_number_writer: match");
		end else begin
			$display("text_console_number_writer: mismatch");
		end
		$finish;
	end

endmodule
